// ----- design/taes_pkg.sv -----
`default_nettype none
package taes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumRegs   = 4;
  localparam int unsigned RegIdxW   = 2;

  localparam logic [127:0] ResetKey = 128'h20436F70_79726967_68742028_43292032;

  localparam logic [RegIdxW-1:0] RegKeyWord0 = 2'd0;
  localparam logic [RegIdxW-1:0] RegKeyWord1 = 2'd1;
  localparam logic [RegIdxW-1:0] RegKeyWord2 = 2'd2;
  localparam logic [RegIdxW-1:0] RegKeyWord3 = 2'd3;

  typedef logic [127:0] block_t;
  typedef block_t round_keys_t [0:NumRounds];

  // Per-stage control that travels with the block.
  typedef struct packed {
    logic        valid;
    logic        mode;
    logic [31:0] tweak;
  } stage_ctl_t;

  function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
      8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
      8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
      8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
      8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
      8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
      8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
      8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
      8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
      8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
      8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
      8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
      8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
      8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
      8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
      8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
      8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
      8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
      8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
      8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
      8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
      8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
      8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
      8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
      8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
      8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
      8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
      8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
      8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
      8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
      8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
      8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
      8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; default: r=8'h7d;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
      4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
      4'd9: r = 8'h1b; 4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[127-8*i -: 8];
  endfunction

  function automatic block_t sub_bytes(input block_t b, input logic inv);
    block_t r;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = inv ? sbox_inv(b[127-8*i -: 8]) : sbox_fwd(b[127-8*i -: 8]);
    end
    return r;
  endfunction

  function automatic block_t shift_rows(input block_t b, input logic inv);
    block_t r;
    for (int rr = 0; rr < 4; rr++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          r[127-8*(rr+4*((c+rr)%4)) -: 8] = b[127-8*(rr+4*c) -: 8];
        end else begin
          r[127-8*(rr+4*c) -: 8] = b[127-8*(rr+4*((c+rr)%4)) -: 8];
        end
      end
    end
    return r;
  endfunction

  function automatic block_t mix_columns(input block_t b, input logic inv);
    block_t r;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = b[127-32*c -: 8];
      a1 = b[119-32*c -: 8];
      a2 = b[111-32*c -: 8];
      a3 = b[103-32*c -: 8];
      if (inv) begin
        // inverse = forward mix after a preconditioning step
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
      end
      r[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      r[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      r[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      r[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return r;
  endfunction

  function automatic block_t next_round_key(input block_t k, input logic [3:0] rnd);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox_fwd(w3[23:16]) ^ rcon(rnd), sbox_fwd(w3[15:8]),
         sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ----- design/taes_key_sched.sv -----
`default_nettype none
module taes_key_sched
  import taes_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire logic [RegIdxW-1:0] idx_i,
  input  wire logic [31:0]       data_i,
  output logic                   busy_o,
  output block_t                 rk_o [0:NumRounds]
);

  block_t     key_q, key_d;
  block_t     rk_q [0:NumRounds];
  logic [3:0] step_q, step_d;
  logic       run_q, run_d;

  always_comb begin
    key_d = key_q;
    if (wr_i) begin
      case (idx_i)
        RegKeyWord0: key_d[127:96] = data_i;
        RegKeyWord1: key_d[95:64]  = data_i;
        RegKeyWord2: key_d[63:32]  = data_i;
        RegKeyWord3: key_d[31:0]   = data_i;
        default:     key_d         = key_q;
      endcase
    end
    run_d  = run_q;
    step_d = step_q;
    if (wr_i) begin
      run_d  = 1'b1;
      step_d = 4'd0;
    end else if (run_q) begin
      if (step_q == 4'(NumRounds)) begin
        run_d = 1'b0;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
  end

  // One round key per cycle after a write; reset starts the same sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= ResetKey;
      run_q  <= 1'b1;
      step_q <= 4'd0;
    end else begin
      key_q  <= key_d;
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      if (step_q == 4'd0) begin
        rk_q[0] <= key_q;
      end else begin
        rk_q[step_q] <= next_round_key(rk_q[step_q - 4'd1], step_q);
      end
    end
  end

  assign busy_o = run_q;
  assign rk_o   = rk_q;

endmodule
`default_nettype wire

// ----- design/taes_round.sv -----
`default_nettype none
module taes_round
  import taes_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire stage_ctl_t  ctl_i,
  input  wire block_t      state_i,
  input  wire block_t      key_i,
  input  wire logic        last_i,
  output stage_ctl_t       ctl_o,
  output block_t           state_o
);

  block_t     sb, mixed_fwd, keyed, result;
  stage_ctl_t ctl_q;
  block_t     state_q;

  // Enc: sub, shift, mix, key. Dec: inv shift, inv sub, key, inv mix. Last round: no mix.
  always_comb begin
    sb        = sub_bytes(shift_rows(state_i, ctl_i.mode), ctl_i.mode);
    mixed_fwd = last_i ? sb : mix_columns(sb, 1'b0);
    keyed     = sb ^ key_i;
    if (ctl_i.mode) begin
      result = last_i ? keyed : mix_columns(keyed, 1'b1);
    end else begin
      result = mixed_fwd ^ key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= result;
  end

  assign ctl_o   = ctl_q;
  assign state_o = state_q;

endmodule
`default_nettype wire

// ----- design/tweaked_aes128_block_cipher_unit.sv -----
`default_nettype none
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+-----------------------------------------
// item in   | in        | start & !busy         | mode_i, block_number_i, data_word0..3_i
// result    | out       | done_o (one cycle)    | result_word0..3_o
// config    | in        | cfg_valid_i&cfg_ready_o| cfg_idx_i, cfg_data_i
//
// Stages from accept to done_o: one input stage (tweak and first key
// add) and ten round stages, one per AES round, then the output stage.
// One item may enter every cycle while busy is low; throughput is one block per clock.
// After reset and after every key write the schedule is rebuilt,
// one round key per cycle; busy holds items off meanwhile.
// Results cannot be stalled, so the pipeline never stops.
module tweaked_aes128_block_cipher_unit
  import taes_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode_i,
  input  wire logic [31:0]        block_number_i,
  input  wire logic [31:0]        data_word0_i,
  input  wire logic [31:0]        data_word1_i,
  input  wire logic [31:0]        data_word2_i,
  input  wire logic [31:0]        data_word3_i,
  output logic                    done_o,
  output logic [31:0]             result_word0_o,
  output logic [31:0]             result_word1_o,
  output logic [31:0]             result_word2_o,
  output logic [31:0]             result_word3_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [RegIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);

  block_t     rk [0:NumRounds];
  logic       ks_busy;
  logic       cfg_wr;
  block_t     in_block, first_key;
  stage_ctl_t ctl [0:NumRounds];
  block_t     st  [0:NumRounds];
  stage_ctl_t in_ctl_q;
  block_t     in_st_q;
  stage_ctl_t out_ctl_q;
  block_t     out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign busy        = ks_busy;

  taes_key_sched u_key_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_wr),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .busy_o (ks_busy),
    .rk_o   (rk)
  );

  // Input stage: tweak on encrypt, then first key add (round key 10 on decrypt).
  always_comb begin
    in_block = {data_word0_i, data_word1_i, data_word2_i, data_word3_i};
    if (!mode_i) begin
      in_block[127:96] = in_block[127:96] ^ block_number_i;
    end
    first_key = mode_i ? rk[NumRounds] : rk[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else begin
      in_ctl_q <= '{valid: start & ~ks_busy, mode: mode_i, tweak: block_number_i};
    end
  end

  always_ff @(posedge clk_i) begin
    in_st_q <= in_block ^ first_key;
  end

  assign ctl[0] = in_ctl_q;
  assign st[0]  = in_st_q;

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    taes_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[r-1]),
      .state_i (st[r-1]),
      .key_i   (ctl[r-1].mode ? rk[NumRounds-r] : rk[r]),
      .last_i  (r == NumRounds),
      .ctl_o   (ctl[r]),
      .state_o (st[r])
    );
  end

  // Output stage: tweak after decrypt.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else begin
      out_ctl_q <= ctl[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= {st[NumRounds][127:96] ^ (ctl[NumRounds].mode ? ctl[NumRounds].tweak : 32'h0),
              st[NumRounds][95:0]};
  end

  assign done_o         = out_ctl_q.valid;
  assign result_word0_o = out_q[127:96];
  assign result_word1_o = out_q[95:64];
  assign result_word2_o = out_q[63:32];
  assign result_word3_o = out_q[31:0];

endmodule
`default_nettype wire
